### hdl/rcd_pkg.sv
// Shared types and codes for the RISC-V instruction class decoder.
package rcd_pkg;

	// Major opcodes (instruction bits 6..0)
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP_FP  = 7'h53;
	localparam logic [6:0] OPC_FLOAD  = 7'h07;
	localparam logic [6:0] OPC_FSTORE = 7'h27;
	localparam logic [6:0] OPC_FENCE  = 7'h0f;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	// funct3 codes: branches
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// funct3 codes: load/store widths
	localparam logic [2:0] F3_BYTE   = 3'd0;
	localparam logic [2:0] F3_HALF   = 3'd1;
	localparam logic [2:0] F3_BYTE_U = 3'd4;
	localparam logic [2:0] F3_HALF_U = 3'd5;

	// funct3 codes: integer ALU
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// funct7 codes for register-register integer ops
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT = 7'h20;

	// funct7 codes for floating ops
	localparam logic [6:0] F7_FCVT_S_W = 7'h68;
	localparam logic [6:0] F7_FCVT_S_D = 7'h20;
	localparam logic [6:0] F7_FCVT_D_S = 7'h21;
	localparam logic [6:0] F7_FMUL_D   = 7'h09;
	localparam logic [6:0] F7_FDIV_S   = 7'h0c;
	localparam logic [6:0] F7_FDIV_D   = 7'h0d;
	localparam logic [6:0] F7_FMV_S_X  = 7'h78;

	// rs2 field values required by the conversions
	localparam logic [4:0] RS2_FROM_W = 5'd0;
	localparam logic [4:0] RS2_FROM_D = 5'd1;
	localparam logic [4:0] RS2_FROM_S = 5'd0;

	// funct3 width selects for loads and stores
	localparam logic [2:0] F3_WORD   = 3'd2;
	localparam logic [2:0] F3_DOUBLE = 3'd3;

	localparam int unsigned INST_W  = 32;
	localparam int unsigned CLASS_W = 6;

	// Instruction classes, numbered in decode order
	typedef enum logic [CLASS_W-1:0] {
		CLS_LUI, CLS_AUIPC, CLS_JAL, CLS_JALR,
		CLS_BEQ, CLS_BNE, CLS_BLT, CLS_BGE, CLS_BLTU, CLS_BGEU,
		CLS_LB, CLS_LH, CLS_LW, CLS_LBU, CLS_LHU,
		CLS_SB, CLS_SH, CLS_SW,
		CLS_ADDI, CLS_SLTI, CLS_SLTIU, CLS_XORI, CLS_ORI, CLS_ANDI,
		CLS_SLLI, CLS_SRLI, CLS_SRAI,
		CLS_ADD, CLS_MUL, CLS_SUB, CLS_SLL, CLS_SLT, CLS_SLTU, CLS_XOR, CLS_DIV,
		CLS_SRL, CLS_SRA, CLS_DIVU, CLS_OR, CLS_AND, CLS_REMU,
		CLS_FCVT_S_W, CLS_FCVT_S_D, CLS_FCVT_D_S, CLS_FMUL_D, CLS_FDIV_S,
		CLS_FDIV_D, CLS_FMV_S_X,
		CLS_FLW, CLS_FLD, CLS_FSW, CLS_FSD,
		CLS_UNIMP, CLS_SCALL, CLS_ILLEGAL
	} inst_class_t;

endpackage

### hdl/rcd_inst_if.sv
// Valid/ready channel carrying one instruction word.
interface rcd_inst_if
	import rcd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [INST_W-1:0] instruction;

	modport source (output valid, output instruction, input ready);
	modport sink (input valid, input instruction, output ready);
endinterface

### hdl/rcd_class_if.sv
// Valid/ready channel carrying one decoded instruction class.
interface rcd_class_if
	import rcd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] inst_class;

	modport source (output valid, output inst_class, input ready);
	modport sink (input valid, input inst_class, output ready);
endinterface

### hdl/rcd_decode.sv
// Combinational instruction class decode.
module rcd_decode
	import rcd_pkg::*;
(
	input  logic [INST_W-1:0] instruction,
	output inst_class_t       inst_class
);

	logic [6:0] opcode;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [4:0] rs2;

	assign opcode = instruction[6:0];
	assign f3     = instruction[14:12];
	assign f7     = instruction[31:25];
	assign rs2    = instruction[24:20];

	// major opcode, then funct3 / funct7 refinement
	always_comb begin
		inst_class = CLS_ILLEGAL;
		unique case (opcode)
			OPC_LUI:   inst_class = CLS_LUI;
			OPC_AUIPC: inst_class = CLS_AUIPC;
			OPC_JAL:   inst_class = CLS_JAL;
			OPC_JALR:  inst_class = CLS_JALR;
			OPC_BRANCH: begin
				unique case (f3)
					F3_BEQ:  inst_class = CLS_BEQ;
					F3_BNE:  inst_class = CLS_BNE;
					F3_BLT:  inst_class = CLS_BLT;
					F3_BGE:  inst_class = CLS_BGE;
					F3_BLTU: inst_class = CLS_BLTU;
					F3_BGEU: inst_class = CLS_BGEU;
					default: inst_class = CLS_ILLEGAL;
				endcase
			end
			OPC_LOAD: begin
				unique case (f3)
					F3_BYTE:   inst_class = CLS_LB;
					F3_HALF:   inst_class = CLS_LH;
					F3_WORD:   inst_class = CLS_LW;
					F3_BYTE_U: inst_class = CLS_LBU;
					F3_HALF_U: inst_class = CLS_LHU;
					default: inst_class = CLS_ILLEGAL;
				endcase
			end
			OPC_STORE: begin
				unique case (f3)
					F3_BYTE: inst_class = CLS_SB;
					F3_HALF: inst_class = CLS_SH;
					F3_WORD: inst_class = CLS_SW;
					default: inst_class = CLS_ILLEGAL;
				endcase
			end
			OPC_OP_IMM: begin
				// shifts: bit 30 alone picks arithmetic right, upper bits unchecked
				unique case (f3)
					F3_ADD:  inst_class = CLS_ADDI;
					F3_SLL:  inst_class = CLS_SLLI;
					F3_SLT:  inst_class = CLS_SLTI;
					F3_SLTU: inst_class = CLS_SLTIU;
					F3_XOR:  inst_class = CLS_XORI;
					F3_SR:   inst_class = instruction[30] ? CLS_SRAI : CLS_SRLI;
					F3_OR:   inst_class = CLS_ORI;
					F3_AND:  inst_class = CLS_ANDI;
					default: inst_class = CLS_ILLEGAL;
				endcase
			end
			OPC_OP: begin
				// funct7 must match exactly
				unique case (f3)
					F3_ADD: begin
						if (f7 == F7_BASE)        inst_class = CLS_ADD;
						else if (f7 == F7_MULDIV) inst_class = CLS_MUL;
						else if (f7 == F7_ALT)    inst_class = CLS_SUB;
					end
					F3_SLL:  if (f7 == F7_BASE) inst_class = CLS_SLL;
					F3_SLT:  if (f7 == F7_BASE) inst_class = CLS_SLT;
					F3_SLTU: if (f7 == F7_BASE) inst_class = CLS_SLTU;
					F3_XOR: begin
						if (f7 == F7_BASE)        inst_class = CLS_XOR;
						else if (f7 == F7_MULDIV) inst_class = CLS_DIV;
					end
					F3_SR: begin
						if (f7 == F7_BASE)        inst_class = CLS_SRL;
						else if (f7 == F7_ALT)    inst_class = CLS_SRA;
						else if (f7 == F7_MULDIV) inst_class = CLS_DIVU;
					end
					F3_OR: if (f7 == F7_BASE) inst_class = CLS_OR;
					F3_AND: begin
						if (f7 == F7_BASE)        inst_class = CLS_AND;
						else if (f7 == F7_MULDIV) inst_class = CLS_REMU;
					end
					default: inst_class = CLS_ILLEGAL;
				endcase
			end
			OPC_OP_FP: begin
				// conversions also check the rs2 field
				unique case (f7)
					F7_FCVT_S_W: if (rs2 == RS2_FROM_W) inst_class = CLS_FCVT_S_W;
					F7_FCVT_S_D: if (rs2 == RS2_FROM_D) inst_class = CLS_FCVT_S_D;
					F7_FCVT_D_S: if (rs2 == RS2_FROM_S) inst_class = CLS_FCVT_D_S;
					F7_FMUL_D:   inst_class = CLS_FMUL_D;
					F7_FDIV_S:   inst_class = CLS_FDIV_S;
					F7_FDIV_D:   inst_class = CLS_FDIV_D;
					F7_FMV_S_X:  inst_class = CLS_FMV_S_X;
					default:     inst_class = CLS_ILLEGAL;
				endcase
			end
			OPC_FLOAD: begin
				if (f3 == F3_WORD)        inst_class = CLS_FLW;
				else if (f3 == F3_DOUBLE) inst_class = CLS_FLD;
			end
			OPC_FSTORE: begin
				if (f3 == F3_WORD)        inst_class = CLS_FSW;
				else if (f3 == F3_DOUBLE) inst_class = CLS_FSD;
			end
			OPC_FENCE: inst_class = CLS_UNIMP;
			OPC_SYSTEM: begin
				// only the all-zero encoding is a system call
				inst_class = (instruction[31:7] == '0) ? CLS_SCALL : CLS_UNIMP;
			end
			default: inst_class = CLS_ILLEGAL;
		endcase
	end

endmodule

### hdl/riscv_instruction_class_decoder_core.sv
// Top level: registered RISC-V instruction class decoder.
//
//   channel | dir | payload                 | handshake
//   instr   | in  | instruction [31:0]      | valid/ready
//   result  | out | inst_class  [5:0]       | valid/ready
//
// Two register stages: the instruction is captured into _s1, decoded by the
// shallow compare logic in rcd_decode, and the class is held in _s2.
// The result is registered in _s2; one item per cycle while the result channel is not stalled.
// arst_n clears both stage valid bits; payload registers are not reset.
// A stalled result holds _s2; _s1 keeps accepting until it is also full.
module riscv_instruction_class_decoder_core
	import rcd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rcd_inst_if.sink     instr,
	rcd_class_if.source  result
);

	logic              valid_s1;
	logic [INST_W-1:0] instruction_s1;
	logic              valid_s2;
	inst_class_t       class_s2;
	inst_class_t       class_dec;
	logic              adv_s1;
	logic              adv_s2;

	// a stage loads when it is empty or its contents move on
	assign adv_s2 = !valid_s2 || result.ready;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign instr.ready       = adv_s1;
	assign result.valid      = valid_s2;
	assign result.inst_class = class_s2;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && instr.valid) begin
			instruction_s1 <= instr.instruction;
		end
	end

	rcd_decode u_decode (
		.instruction (instruction_s1),
		.inst_class  (class_dec)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			class_s2 <= class_dec;
		end
	end

	// a new result only comes from a filled input stage
	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result valid without a transaction in the input stage");

	// a full pipeline with a stalled output keeps the input stage loaded
	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !result.ready) |=> valid_s1)
		else $error("input stage dropped a transaction during output stall");

	// input is refused only when both stages are full and the output stalls
	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!instr.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("input refused with room in the pipeline");

	// decoded class stays within the defined codes
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.inst_class <= CLS_ILLEGAL))
		else $error("result class out of range");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the registered RISC-V instruction class decoder.
`timescale 1ns / 1ps

module tb
	import rcd_pkg::*;
;

	localparam int HALF_PERIOD    = 1;
	localparam int RESET_CYCLES   = 8;
	localparam int RAND_PER_PHASE = 380;
	localparam int HOLD_LEN       = 200;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_PRINTED    = 40;
	localparam int NUM_CLASSES    = int'(CLS_ILLEGAL) + 1;

	localparam int N_KNOWN_OPS = 14;
	localparam logic [6:0] KNOWN_OPS [N_KNOWN_OPS] = '{
		OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
		OPC_OP_IMM, OPC_OP, OPC_OP_FP, OPC_FLOAD, OPC_FSTORE, OPC_FENCE, OPC_SYSTEM
	};
	localparam int N_FP_F7 = 7;
	localparam logic [6:0] FP_F7S [N_FP_F7] = '{
		F7_FCVT_S_W, F7_FCVT_S_D, F7_FCVT_D_S, F7_FMUL_D, F7_FDIV_S, F7_FDIV_D, F7_FMV_S_X
	};

	typedef enum int {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE} phase_t;

	// Directed rows: class typed in, or taken from the decode predictor
	localparam bit BY_MODEL = 1'b0;
	localparam bit TYPED    = 1'b1;
	typedef struct packed {
		logic [INST_W-1:0] word;
		bit                typed;
		inst_class_t       cls;
	} directed_row_t;

	localparam int N_DIRECTED = 27;
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{32'h0000_0000, TYPED,    CLS_ILLEGAL}, // all zeros: unknown opcode
		'{32'hffff_ffff, TYPED,    CLS_ILLEGAL}, // all ones: unknown opcode
		'{32'hffff_f037, BY_MODEL, CLS_ILLEGAL}, // lui, full immediate
		'{32'h0000_006f, BY_MODEL, CLS_ILLEGAL}, // jal
		'{32'h0000_2063, TYPED,    CLS_ILLEGAL}, // branch, unassigned funct3
		'{32'h0000_3063, TYPED,    CLS_ILLEGAL},
		'{32'hffff_f0e3, BY_MODEL, CLS_ILLEGAL}, // bgeu, upper bits set
		'{32'h0000_6003, TYPED,    CLS_ILLEGAL}, // load, unassigned funct3
		'{32'h0000_3003, TYPED,    CLS_ILLEGAL},
		'{32'h0000_3023, TYPED,    CLS_ILLEGAL}, // store, unassigned funct3
		'{32'h4000_5013, BY_MODEL, CLS_ILLEGAL}, // srai: bit 30 alone
		'{32'hbfff_5013, BY_MODEL, CLS_ILLEGAL}, // srli with other upper bits set
		'{32'hfe00_1013, BY_MODEL, CLS_ILLEGAL}, // slli ignores funct7
		'{32'h0400_0033, TYPED,    CLS_ILLEGAL}, // add with bad funct7
		'{32'h0200_7033, BY_MODEL, CLS_ILLEGAL}, // remu
		'{32'h4000_5033, BY_MODEL, CLS_ILLEGAL}, // sra
		'{32'h4000_1033, TYPED,    CLS_ILLEGAL}, // sll with alt funct7
		'{32'hd000_0053, BY_MODEL, CLS_ILLEGAL}, // fcvt.s.w
		'{32'hd010_0053, TYPED,    CLS_ILLEGAL}, // fcvt.s.w, wrong rs2
		'{32'h4000_0053, TYPED,    CLS_ILLEGAL}, // fcvt.s.d, wrong rs2
		'{32'h13ff_ffd3, BY_MODEL, CLS_ILLEGAL}, // fmul.d, all other bits set
		'{32'hfe00_0053, TYPED,    CLS_ILLEGAL}, // unknown float funct7
		'{32'h0000_4007, TYPED,    CLS_ILLEGAL}, // float load, bad width
		'{32'h0000_3027, BY_MODEL, CLS_ILLEGAL}, // fsd
		'{32'hffff_ff8f, TYPED,    CLS_UNIMP},   // fence, any other bits
		'{32'h0000_0073, TYPED,    CLS_SCALL},   // system call
		'{32'h0000_00f3, TYPED,    CLS_UNIMP}    // system, bit 7 set
	};

	typedef struct {
		logic [INST_W-1:0] word;
		inst_class_t       cls;
	} pending_decode_t;

	logic clk;
	logic arst_n;

	rcd_inst_if  inst_ch ();
	rcd_class_if class_ch ();

	riscv_instruction_class_decoder_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (inst_ch),
		.result (class_ch)
	);

	pending_decode_t pending_classes [$];
	phase_t          test_phase     = PH_STEADY;
	int unsigned     send_idle_pct  = 0;
	int unsigned     recv_stall_pct = 0;
	int              mismatch_count = 0;
	int              sent_count     = 0;
	int              decoded_count  = 0;
	int              input_stalls   = 0;
	bit              classes_seen [64];

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Decode predictor: class of one instruction word
	function automatic inst_class_t decode_class(input logic [INST_W-1:0] w);
		logic [6:0]  opc;
		logic [6:0]  f7;
		logic [2:0]  f3;
		logic [4:0]  rs2;
		inst_class_t cls;
		opc = w[6:0];
		f3  = w[14:12];
		f7  = w[31:25];
		rs2 = w[24:20];
		cls = CLS_ILLEGAL;
		case (opc)
			OPC_LUI:   cls = CLS_LUI;
			OPC_AUIPC: cls = CLS_AUIPC;
			OPC_JAL:   cls = CLS_JAL;
			OPC_JALR:  cls = CLS_JALR;
			OPC_BRANCH: begin
				case (f3)
					F3_BEQ:  cls = CLS_BEQ;
					F3_BNE:  cls = CLS_BNE;
					F3_BLT:  cls = CLS_BLT;
					F3_BGE:  cls = CLS_BGE;
					F3_BLTU: cls = CLS_BLTU;
					F3_BGEU: cls = CLS_BGEU;
					default: ;
				endcase
			end
			OPC_LOAD: begin
				case (f3)
					F3_BYTE:   cls = CLS_LB;
					F3_HALF:   cls = CLS_LH;
					F3_WORD:   cls = CLS_LW;
					F3_BYTE_U: cls = CLS_LBU;
					F3_HALF_U: cls = CLS_LHU;
					default: ;
				endcase
			end
			OPC_STORE: begin
				case (f3)
					F3_BYTE: cls = CLS_SB;
					F3_HALF: cls = CLS_SH;
					F3_WORD: cls = CLS_SW;
					default: ;
				endcase
			end
			OPC_OP_IMM: begin
				// shifts: bit 30 alone picks arithmetic right shift
				case (f3)
					F3_ADD:  cls = CLS_ADDI;
					F3_SLT:  cls = CLS_SLTI;
					F3_SLTU: cls = CLS_SLTIU;
					F3_XOR:  cls = CLS_XORI;
					F3_OR:   cls = CLS_ORI;
					F3_AND:  cls = CLS_ANDI;
					F3_SLL:  cls = CLS_SLLI;
					default: cls = w[30] ? CLS_SRAI : CLS_SRLI;
				endcase
			end
			OPC_OP: begin
				// funct7 must match exactly
				case (f3)
					F3_ADD: begin
						if (f7 == F7_BASE) cls = CLS_ADD;
						else if (f7 == F7_MULDIV) cls = CLS_MUL;
						else if (f7 == F7_ALT) cls = CLS_SUB;
					end
					F3_SLL:  if (f7 == F7_BASE) cls = CLS_SLL;
					F3_SLT:  if (f7 == F7_BASE) cls = CLS_SLT;
					F3_SLTU: if (f7 == F7_BASE) cls = CLS_SLTU;
					F3_XOR: begin
						if (f7 == F7_BASE) cls = CLS_XOR;
						else if (f7 == F7_MULDIV) cls = CLS_DIV;
					end
					F3_SR: begin
						if (f7 == F7_BASE) cls = CLS_SRL;
						else if (f7 == F7_ALT) cls = CLS_SRA;
						else if (f7 == F7_MULDIV) cls = CLS_DIVU;
					end
					F3_OR: if (f7 == F7_BASE) cls = CLS_OR;
					default: begin
						if (f7 == F7_BASE) cls = CLS_AND;
						else if (f7 == F7_MULDIV) cls = CLS_REMU;
					end
				endcase
			end
			OPC_OP_FP: begin
				// conversions also check rs2; the rest only funct7
				case (f7)
					F7_FCVT_S_W: if (rs2 == RS2_FROM_W) cls = CLS_FCVT_S_W;
					F7_FCVT_S_D: if (rs2 == RS2_FROM_D) cls = CLS_FCVT_S_D;
					F7_FCVT_D_S: if (rs2 == RS2_FROM_S) cls = CLS_FCVT_D_S;
					F7_FMUL_D:   cls = CLS_FMUL_D;
					F7_FDIV_S:   cls = CLS_FDIV_S;
					F7_FDIV_D:   cls = CLS_FDIV_D;
					F7_FMV_S_X:  cls = CLS_FMV_S_X;
					default: ;
				endcase
			end
			OPC_FLOAD: begin
				if (f3 == F3_WORD) cls = CLS_FLW;
				else if (f3 == F3_DOUBLE) cls = CLS_FLD;
			end
			OPC_FSTORE: begin
				if (f3 == F3_WORD) cls = CLS_FSW;
				else if (f3 == F3_DOUBLE) cls = CLS_FSD;
			end
			OPC_FENCE:  cls = CLS_UNIMP;
			OPC_SYSTEM: cls = (w[31:7] == '0) ? CLS_SCALL : CLS_UNIMP;
			default: ;
		endcase
		return cls;
	endfunction

	// Mostly well-formed words with random fields, some raw noise
	function automatic logic [INST_W-1:0] random_word();
		logic [INST_W-1:0] w;
		int unsigned       pick;
		w = $urandom;
		if ($urandom_range(0, 99) < 12)
			return w;
		w[6:0] = KNOWN_OPS[$urandom_range(0, N_KNOWN_OPS - 1)];
		case (w[6:0])
			OPC_OP: begin
				pick = $urandom_range(0, 9);
				if (pick < 4) w[31:25] = F7_BASE;
				else if (pick < 7) w[31:25] = F7_MULDIV;
				else if (pick < 9) w[31:25] = F7_ALT;
			end
			OPC_OP_FP: begin
				pick = $urandom_range(0, N_FP_F7);
				if (pick < N_FP_F7) w[31:25] = FP_F7S[pick];
				if ($urandom_range(0, 3) != 0)
					w[24:20] = $urandom_range(0, 1) ? RS2_FROM_D : RS2_FROM_W;
			end
			OPC_SYSTEM: if ($urandom_range(0, 2) == 0) w[31:7] = '0;
			default: ;
		endcase
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Offer one instruction and log its expected class on acceptance
	task automatic send_word(input logic [INST_W-1:0] w, input inst_class_t cls);
		bit took;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			inst_ch.valid <= 1'b0;
			@(posedge clk);
		end
		inst_ch.valid       <= 1'b1;
		inst_ch.instruction <= w;
		do begin
			@(negedge clk);
			took = inst_ch.ready;
			if (!took && test_phase == PH_PRESSURE)
				input_stalls++;
			@(posedge clk);
		end while (!took);
		pending_classes.push_back('{word: w, cls: cls});
		sent_count++;
	endtask

	task automatic run_phase(input phase_t ph, input int unsigned send_pct,
			input int unsigned recv_pct);
		logic [INST_W-1:0] w;
		test_phase     = ph;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < RAND_PER_PHASE; i++) begin
			w = random_word();
			send_word(w, decode_class(w));
		end
	endtask

	// Result consumer: random stalls, one long hold-off in the pressure phase
	initial begin : result_sink
		int hold_cycles;
		hold_cycles = 0;
		class_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (test_phase == PH_PRESSURE && hold_cycles < HOLD_LEN) begin
				hold_cycles++;
				class_ch.ready <= 1'b0;
			end else begin
				class_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Compare each result transaction against the oldest pending class
	always @(negedge clk) begin : result_check
		pending_decode_t head;
		if (arst_n && class_ch.valid && class_ch.ready) begin
			if (pending_classes.size() == 0) begin
				report_mismatch($sformatf("unexpected result class %0d",
					class_ch.inst_class));
			end else begin
				head = pending_classes.pop_front();
				decoded_count++;
				if (class_ch.inst_class !== head.cls)
					report_mismatch($sformatf("word %h: class %0d, want %0d (%s)",
						head.word, class_ch.inst_class, head.cls, head.cls.name()));
				else
					classes_seen[class_ch.inst_class] = 1'b1;
			end
		end
	end

	// Stimulus: reset, directed rows, then random phases
	initial begin : stimulus
		int seen;
		inst_ch.valid       <= 1'b0;
		inst_ch.instruction <= '0;
		arst_n              <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(DIRECTED[i].word, DIRECTED[i].typed ? DIRECTED[i].cls
				: decode_class(DIRECTED[i].word));

		run_phase(PH_STEADY, 0, 0);
		run_phase(PH_SEND_IDLE, 68, 0);
		run_phase(PH_RECV_STALL, 0, 68);
		run_phase(PH_BOTH, 31, 31);
		run_phase(PH_PRESSURE, 0, 31);

		inst_ch.valid <= 1'b0;
		while (pending_classes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		seen = 0;
		for (int c = 0; c < NUM_CLASSES; c++)
			seen += classes_seen[c];
		$display("Decoded %0d of %0d instruction words (%0d directed), %0d mismatches.",
			decoded_count, sent_count, N_DIRECTED, mismatch_count);
		$display("Classes seen: %0d of %0d; input stalls under output hold-off: %0d.",
			seen, NUM_CLASSES, input_stalls);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#2_000_000;
		$display("Timeout with %0d results outstanding", pending_classes.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
